### rtl/core/rtsp_pkg.sv
// Shared types and codes for the reference-counted slot pool core.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package rtsp_pkg;

    // Request beat: fields in order cmd, key, slot_index
    typedef struct packed {
        logic [0:0]  cmd;
        logic [63:0] key;
        logic [3:0]  slot_index;
    } rtsp_req_t;

    // Response beat: fields in order slot, status, ref_count, used_count
    typedef struct packed {
        logic [3:0]  slot;
        logic [2:0]  status;
        logic [15:0] ref_count;
        logic [4:0]  used_count;
    } rtsp_rsp_t;

    localparam logic [0:0] CMD_ACQUIRE = 1'b0;
    localparam logic [0:0] CMD_RELEASE = 1'b1;

    localparam logic [2:0] ST_REUSED     = 3'd0;
    localparam logic [2:0] ST_NEW        = 3'd1;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [2:0] ST_STILL_USED = 3'd3;
    localparam logic [2:0] ST_NOW_FREE   = 3'd4;
    localparam logic [2:0] ST_IGNORED    = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_COMMIT
    } rtsp_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the request beat
        logic look;    // register tag match and free search
        logic commit;  // apply update and load the response register
    } rtsp_ctl_t;

endpackage

`default_nettype wire

### rtl/core/rtsp_ctrl.sv
// Sequencer for the slot pool: idle, look, commit, plus response valid.
// Depends on rtsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtsp_ctrl
    import rtsp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rtsp_ctl_t      ctl
);

    rtsp_state_t state_reg;
    rtsp_state_t state_next;
    logic        rsp_valid_reg;
    logic        rsp_valid_next;
    logic        can_commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        can_commit = !rsp_valid_reg || !rsp_stall;
        ctl        = '0;
        req_stall  = 1'b1;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_stall  = 1'b0;
                ctl.load   = req_valid;
                state_next = req_valid ? S_LOOK : S_IDLE;
            end
            S_LOOK:
            begin
                ctl.look   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the response register is free
                if (can_commit)
                begin
                    ctl.commit = 1'b1;
                    req_stall  = 1'b0;
                    ctl.load   = req_valid;
                    state_next = req_valid ? S_LOOK : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        rsp_valid_next = ctl.commit || (rsp_valid_reg && rsp_stall);
    end

    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTH
    a_load_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> state_reg == S_LOOK)
        else $error("loaded beat did not enter look");

    a_look_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOOK |=> state_reg == S_COMMIT)
        else $error("look not followed by commit");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |=> rsp_valid_reg)
        else $error("commit did not present a response");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !ctl.commit)
        else $error("commit over a held response");
`endif

endmodule

`default_nettype wire

### rtl/core/rtsp_dpath.sv
// Slot cells (tags, counts), live counter, search registers and response register.
// Depends on rtsp_pkg; driven by rtsp_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module rtsp_dpath
    import rtsp_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire rtsp_ctl_t  ctl,
    input  wire rtsp_req_t  req_data,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_data,
    output rtsp_rsp_t       rsp_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LIVE_W = $clog2(SLOTS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    logic [4:0]            slot_count_reg;
    logic [63:0]           tag_reg [SLOTS];
    logic [COUNT_BITS-1:0] refs_reg [SLOTS];
    logic [LIVE_W-1:0]     live_reg;
    logic [LIVE_W-1:0]     live_next;

    // captured request
    logic [0:0]            cmd_reg;
    logic [63:0]           key_reg;
    logic [3:0]            idx_reg;

    // search results
    logic                  hit_any_reg;
    logic [SLOT_W-1:0]     hit_idx_reg;
    logic                  free_any_reg;
    logic [SLOT_W-1:0]     free_idx_reg;
    logic                  rel_any_reg;
    logic [COUNT_BITS-1:0] sel_refs_reg;

    logic                  hit_any_next;
    logic [SLOT_W-1:0]     hit_idx_next;
    logic                  free_any_next;
    logic [SLOT_W-1:0]     free_idx_next;
    logic                  rel_any_next;
    logic [COUNT_BITS-1:0] sel_refs_next;

    // commit
    logic                  wr_en;
    logic                  tag_wr_en;
    logic [SLOT_W-1:0]     wr_idx;
    logic [COUNT_BITS-1:0] wr_refs;
    logic [2:0]            status_next;
    logic [COUNT_BITS-1:0] rsp_refs;
    logic                  slot_valid;
    logic [SLOT_W+3:0]     idx_ext;
    logic [SLOT_W+3:0]     slot_ext;
    logic [COUNT_BITS+15:0] refs_ext;
    logic [LIVE_W+4:0]     live_ext;
    rtsp_rsp_t             rsp_reg;

    assign idx_ext = {{SLOT_W{1'b0}}, idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            slot_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= req_data.cmd;
            key_reg <= req_data.key;
            idx_reg <= req_data.slot_index;
        end
        if (ctl.look)
        begin
            hit_any_reg  <= hit_any_next;
            hit_idx_reg  <= hit_idx_next;
            free_any_reg <= free_any_next;
            free_idx_reg <= free_idx_next;
            rel_any_reg  <= rel_any_next;
            sel_refs_reg <= sel_refs_next;
        end
    end

    // search: lowest live tag match and lowest free slot below the limit
    always_comb
    begin
        hit_any_next  = 1'b0;
        hit_idx_next  = '0;
        free_any_next = 1'b0;
        free_idx_next = '0;
        rel_any_next  = 1'b0;
        sel_refs_next = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (32'(i) < 32'(slot_count_reg))
            begin
                if (refs_reg[i] != '0 && tag_reg[i] == key_reg)
                begin
                    hit_any_next = 1'b1;
                    hit_idx_next = SLOT_W'(i);
                end
                if (refs_reg[i] == '0)
                begin
                    free_any_next = 1'b1;
                    free_idx_next = SLOT_W'(i);
                end
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (cmd_reg == CMD_RELEASE)
            begin
                if (32'(i) == 32'(idx_reg))
                begin
                    sel_refs_next = refs_reg[i];
                    rel_any_next  = (32'(i) < 32'(slot_count_reg)) && (refs_reg[i] != '0);
                end
            end
            else if (32'(i) == 32'(hit_idx_next))
            begin
                sel_refs_next = refs_reg[i];
            end
        end
    end

    // decide the update from the registered search
    always_comb
    begin
        wr_en       = 1'b0;
        tag_wr_en   = 1'b0;
        wr_idx      = '0;
        wr_refs     = '0;
        live_next   = live_reg;
        status_next = ST_IGNORED;
        rsp_refs    = '0;
        slot_valid  = 1'b0;
        if (cmd_reg == CMD_ACQUIRE)
        begin
            if (hit_any_reg)
            begin
                wr_en       = 1'b1;
                wr_idx      = hit_idx_reg;
                wr_refs     = (sel_refs_reg == COUNT_MAX) ? sel_refs_reg
                                                         : sel_refs_reg + COUNT_ONE;
                status_next = ST_REUSED;
                rsp_refs    = wr_refs;
                slot_valid  = 1'b1;
            end
            else if (free_any_reg)
            begin
                wr_en       = 1'b1;
                tag_wr_en   = 1'b1;
                wr_idx      = free_idx_reg;
                wr_refs     = COUNT_ONE;
                live_next   = live_reg + LIVE_W'(1);
                status_next = ST_NEW;
                rsp_refs    = COUNT_ONE;
                slot_valid  = 1'b1;
            end
            else
            begin
                status_next = ST_EXHAUSTED;
            end
        end
        else if (rel_any_reg)
        begin
            wr_en      = 1'b1;
            wr_idx     = idx_ext[SLOT_W-1:0];
            wr_refs    = sel_refs_reg - COUNT_ONE;
            slot_valid = 1'b1;
            if (wr_refs == '0)
            begin
                live_next   = live_reg - LIVE_W'(1);
                status_next = ST_NOW_FREE;
            end
            else
            begin
                status_next = ST_STILL_USED;
                rsp_refs    = wr_refs;
            end
        end
        slot_ext = slot_valid ? {4'b0, wr_idx} : '0;
        refs_ext = {16'b0, rsp_refs};
        live_ext = {5'b0, live_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                refs_reg[i] <= '0;
            end
        end
        else if (ctl.commit)
        begin
            live_reg <= live_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (wr_en && 32'(i) == 32'(wr_idx))
                begin
                    refs_reg[i] <= wr_refs;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (ctl.commit && tag_wr_en && 32'(i) == 32'(wr_idx))
            begin
                tag_reg[i] <= key_reg;
            end
        end
        if (ctl.commit)
        begin
            rsp_reg.slot       <= slot_ext[3:0];
            rsp_reg.status     <= status_next;
            rsp_reg.ref_count  <= refs_ext[15:0];
            rsp_reg.used_count <= live_ext[4:0];
        end
    end

    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

### rtl/core/refcounted_tagged_slot_pool_core.sv
// Top level of the reference-counted slot pool with 64-bit tag match.
// Depends on rtsp_pkg, rtsp_ctrl and rtsp_dpath.
//
// Each request beat either acquires a slot by key or releases a slot by index.
// An acquire first reuses the lowest live slot whose tag equals the key (its
// count saturates at the top), otherwise claims the lowest free slot below the
// active limit (min of slot_count and SLOTS) and reports a fresh assignment,
// otherwise reports the pool exhausted. A release of a live slot below the
// limit lowers its count and frees it at zero; any other release is ignored.
// One response beat per request carries slot, status, the new count and the
// number of live slots. A request passes the look state, which compares the
// key against every slot tag and searches for a free slot, then the commit
// state, which writes the update into the slot cells and response register; a
// new request is taken in the commit state. A response waiting on rsp_stall
// holds the commit of the next beat. Write slot_count on the cfg port (always
// ready) only while no request is in flight, which the core does not enforce;
// counts and the live counter clear at reset, tags need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_tagged_slot_pool_core
    import rtsp_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // request channel
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire rtsp_req_t  req_data,
    // response channel
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rtsp_rsp_t       rsp_data,
    // slot_count write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] cfg_data
);

    rtsp_ctl_t ctl;

    // the register accepts every write beat
    assign cfg_ready = 1'b1;

    rtsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    rtsp_dpath #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .req_data (req_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .rsp_data (rsp_data)
    );

endmodule

`default_nettype wire
